// ----- hw/rtl/ogeb_pkg.sv -----
// Shared types, constants and helpers for the occupancy grid edge buffer.
// Used by ogeb_cell and the top level occupancy_grid_edge_buffer_unit.
// No dependencies.
package ogeb_pkg;

  localparam int DEF_RADIUS     = 3;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int DIM_W      = 11;
  localparam int CODE_W     = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_ADDR_W = 2;

  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 11'd200;
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 11'd200;
  localparam logic [CODE_W-1:0] RST_OCC_CODE     = 8'd100;
  localparam logic [CODE_W-1:0] RST_UNK_CODE     = 8'hFF;

  // One stored cell: occupied flag above the value.
  localparam int SLOT_W = CODE_W + 1;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_OCC_CODE     = 2'd2,
    REG_UNK_CODE     = 2'd3
  } cfg_reg_t;

  localparam logic KIND_CELL  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // True when tap (row k, column j) of the window lies inside the disk.
  function automatic logic in_disk(input int k, input int j, input int rad);
    int dy;
    int dx;
    dy = rad - k;
    dx = rad - j;
    return (dy * dy + dx * dx) < ((rad + 1) * (rad + 1));
  endfunction

endpackage

// ----- hw/rtl/ogeb_cell.sv -----
// One row cell of the window chain: a horizontal tap shift and, when HAS_LINE is set, a line memory.
// Depends on ogeb_pkg.
module ogeb_cell import ogeb_pkg::*; #(
  parameter int RADIUS    = DEF_RADIUS,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter bit HAS_LINE  = 1'b1
) (
  input  logic                               clk,
  input  logic                               adv,
  input  logic [$clog2(MAX_WIDTH)-1:0]       wr_col,
  input  logic [$clog2(MAX_WIDTH)-1:0]       rd_col,
  input  slot_t                              din,
  output slot_t                              dout,
  output logic [2*RADIUS:0][SLOT_W-1:0]      taps
);

  localparam int NTAP = 2 * RADIUS + 1;

  slot_t tap_r [NTAP];

  always_ff @(posedge clk) begin
    if (adv) begin
      tap_r[0] <= din;
      for (int j = 1; j < NTAP; j++) begin
        tap_r[j] <= tap_r[j-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NTAP; j++) begin
      taps[j] = tap_r[j];
    end
  end

  generate
    if (HAS_LINE) begin : g_line
      slot_t mem [MAX_WIDTH];
      slot_t rd_r;

      // The read runs one transaction ahead; a one-cell row needs the bypass.
      always_ff @(posedge clk) begin
        if (adv) begin
          mem[wr_col] <= din;
          if (rd_col == wr_col) begin
            rd_r <= din;
          end else begin
            rd_r <= mem[rd_col];
          end
        end
      end
      assign dout = rd_r;
    end else begin : g_noline
      assign dout = '0;
    end
  endgenerate

endmodule

// ----- hw/rtl/occupancy_grid_edge_buffer_unit.sv -----
// Top level of the occupancy grid edge buffer: counters, row cell chain, output stage.
// Depends on ogeb_pkg and ogeb_cell.
//
// Usage: grid cells enter on the in_ channel in row-major order (in_tuser 0),
// one transaction per cycle while in_tready is high. Each cell leaves on the
// out_ channel in the same order, RADIUS rows plus RADIUS cells later, with
// out_tuser set when it was rewritten to the unknown code. After the last cell
// of a frame, each input transaction (flush or cell) drains one remaining cell;
// out_tlast marks the frame's last cell. Flush transactions outside a drain
// produce nothing. Throughput is one transaction per cycle while the receiver
// accepts results; a result released by an input transaction passes through
// the window register and then the output register. The rate is set by the row
// chain: 2*RADIUS line memories, each written and read once per transaction.
// Reset clears the counters and the output valid flag and restores the register
// defaults; line memories are not cleared. When the receiver stalls, one result
// waits in the output register and one in the window; in_tready then drops.
// Frame size is latched at the first cell of each frame.
module occupancy_grid_edge_buffer_unit import ogeb_pkg::*; #(
  parameter int RADIUS     = DEF_RADIUS,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic signed [CODE_W-1:0]     in_tdata,   // [7:0] cell_value
  input  logic                         in_tuser,   // [0] kind
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic signed [CODE_W-1:0]     out_tdata,  // [7:0] out_value
  output logic                         out_tuser,  // [0] out_marked
  output logic                         out_tlast,
  input  logic                         cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int NROW = 2 * RADIUS + 1;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT);
  localparam int HH   = $clog2(MAX_HEIGHT + 1);
  localparam int PW   = WW + HH;

  logic [DIM_W-1:0]  cfg_w_r, cfg_h_r;
  logic [CODE_W-1:0] cfg_occ_r, cfg_unk_r;

  logic [WW-1:0] w_cur_r, w_cur_nxt;
  logic [HH-1:0] h_cur_r, h_cur_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [HH-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [HW-1:0] out_row_r, out_row_nxt;
  logic          drain_r, drain_nxt;

  logic pend_r, pend_nxt;
  logic border_r, border_nxt;
  logic last_r, last_nxt;
  logic short_r, short_nxt;

  logic                     out_vld_r;
  logic signed [CODE_W-1:0] out_val_r;
  logic                     out_mark_r, out_last_r;

  logic          adv, move, first, emit_now, last_now, col_wrap;
  logic [WW-1:0] clamp_w, w_eff;
  logic [HH-1:0] clamp_h, h_eff;
  logic [PW-1:0] in_pos, lag_pos;
  logic [CW-1:0] rd_col;
  slot_t         din0;
  slot_t         cen;
  logic          hit, occ_c, marked;

  slot_t                          dout [NROW];
  logic [NROW-1:0][NROW-1:0][SLOT_W-1:0] taps;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= RST_FRAME_WIDTH;
      cfg_h_r   <= RST_FRAME_HEIGHT;
      cfg_occ_r <= RST_OCC_CODE;
      cfg_unk_r <= RST_UNK_CODE;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_FRAME_WIDTH:  cfg_w_r   <= cfg_wdata;
        REG_FRAME_HEIGHT: cfg_h_r   <= cfg_wdata;
        REG_OCC_CODE:     cfg_occ_r <= cfg_wdata[CODE_W-1:0];
        REG_UNK_CODE:     cfg_unk_r <= cfg_wdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_w_r == '0) begin
      clamp_w = WW'(1);
    end else if (int'(cfg_w_r) > MAX_WIDTH) begin
      clamp_w = WW'(MAX_WIDTH);
    end else begin
      clamp_w = WW'(cfg_w_r);
    end
    if (cfg_h_r == '0) begin
      clamp_h = HH'(1);
    end else if (int'(cfg_h_r) > MAX_HEIGHT) begin
      clamp_h = HH'(MAX_HEIGHT);
    end else begin
      clamp_h = HH'(cfg_h_r);
    end
  end

  assign move      = pend_r && (!out_vld_r || out_tready);
  assign in_tready = !pend_r || !out_vld_r || out_tready;
  assign adv       = in_tvalid && in_tready && (drain_r || in_tuser == KIND_CELL);
  assign first     = !drain_r && in_col_r == '0 && in_row_r == '0;
  assign w_eff     = first ? clamp_w : w_cur_r;
  assign h_eff     = first ? clamp_h : h_cur_r;

  always_comb begin
    in_pos    = PW'(in_row_r) * PW'(w_eff) + PW'(in_col_r);
    lag_pos   = PW'(RADIUS) * PW'(w_eff) + PW'(RADIUS);
    emit_now  = drain_r || in_pos >= lag_pos;
    short_nxt = PW'(w_eff) * PW'(h_eff) < lag_pos;
    last_now = emit_now && (int'(out_row_r) + 1 == int'(h_eff)) &&
               (int'(out_col_r) + 1 == int'(w_eff));
    col_wrap = (int'(in_col_r) + 1 >= int'(w_eff));

    w_cur_nxt  = w_eff;
    h_cur_nxt  = h_eff;
    in_row_nxt = in_row_r;
    drain_nxt  = drain_r;
    if (last_now || col_wrap) begin
      in_col_nxt = '0;
    end else begin
      in_col_nxt = in_col_r + CW'(1);
    end
    if (!drain_r && col_wrap) begin
      in_row_nxt = in_row_r + HH'(1);
      drain_nxt  = (int'(in_row_r) + 1 >= int'(h_eff));
    end
    if (last_now) begin
      in_row_nxt = '0;
      drain_nxt  = 1'b0;
    end

    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (emit_now) begin
      if (last_now) begin
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (int'(out_col_r) + 1 >= int'(w_eff)) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + HW'(1);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end

    border_nxt = int'(out_col_r) <= RADIUS ||
                 int'(out_col_r) + RADIUS + 1 >= int'(w_eff) ||
                 int'(out_row_r) <= RADIUS ||
                 int'(out_row_r) + RADIUS + 1 >= int'(h_eff);
    last_nxt   = last_now;

    if (adv) begin
      pend_nxt = emit_now;
    end else if (move) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end
  end

  assign rd_col = in_col_nxt;
  assign din0   = drain_r ? slot_t'(0) : {in_tdata == cfg_occ_r, in_tdata};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_cur_r   <= '0;
      h_cur_r   <= '0;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      drain_r   <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (adv) begin
        w_cur_r   <= w_cur_nxt;
        h_cur_r   <= h_cur_nxt;
        in_col_r  <= in_col_nxt;
        in_row_r  <= in_row_nxt;
        out_col_r <= out_col_nxt;
        out_row_r <= out_row_nxt;
        drain_r   <= drain_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      border_r <= border_nxt;
      last_r   <= last_nxt;
      short_r  <= short_nxt;
    end
  end

  generate
    for (genvar k = 0; k < NROW; k++) begin : g_row
      ogeb_cell #(
        .RADIUS    (RADIUS),
        .MAX_WIDTH (MAX_WIDTH),
        .HAS_LINE  (k < NROW - 1)
      ) u_cell (
        .clk    (clk),
        .adv    (adv),
        .wr_col (in_col_r),
        .rd_col (rd_col),
        .din    ((k == 0) ? din0 : dout[(k == 0) ? 0 : k-1]),
        .dout   (dout[k]),
        .taps   (taps[k])
      );
    end
  endgenerate

  // A frame with fewer cells than the lag starts its output while the chain
  // still holds the whole frame, so the cell leaving sits height rows down.
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < NROW; k++) begin
      for (int j = 0; j < NROW; j++) begin
        if (in_disk(k, j, RADIUS)) begin
          hit = hit | taps[k][j][SLOT_W-1];
        end
      end
    end
    cen = taps[RADIUS][RADIUS];
    if (short_r) begin
      for (int k = 0; k < NROW; k++) begin
        if (int'(h_cur_r) == k) begin
          cen = taps[k][0];
        end
      end
    end
    occ_c  = cen[SLOT_W-1];
    marked = !occ_c && (border_r || hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (move) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_val_r  <= marked ? cfg_unk_r : cen[CODE_W-1:0];
      out_mark_r <= marked;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_mark_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- hw/rtl/ogeb_checker.sv -----
// Port-level checks for occupancy_grid_edge_buffer_unit, bound to the top level.
// Depends on ogeb_pkg.
module ogeb_checker import ogeb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [CODE_W-1:0] out_tdata,
  input logic              out_tuser,
  input logic              out_tlast
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_idle_ready: assert property (@(posedge clk) !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output register");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind occupancy_grid_edge_buffer_unit ogeb_checker u_ogeb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
